>>> src/iira_pkg.sv
// Shared types and constants for the indexed insert/remove array core.
// Depends on nothing; imported by indexed_insert_remove_array_core.
package iira_pkg;

  // Store geometry
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the stream payloads
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 7;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int IN_DATA_W  = ((POS_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_REPLACE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SHIFT_UP,
    S_INS_LAST,
    S_SHIFT_DN,
    S_RESP
  } fsm_t;

endpackage

>>> src/indexed_insert_remove_array_core.sv
// Indexed insert/remove array core: an ordered word store with a live count.
// Depends on iira_pkg for geometry, command, status and state types.
//
//  channel | dir | tdata (low bit up)               | tuser
//  s_*     | in  | position[6:0], value[38:7]       | cmd[1:0]
//  m_*     | out | old_value[31:0], count[38:32]   | status[1:0]
//
// One transfer in, one transfer out. Insert moves every entry from the index
// up, remove every entry above the index down: the memory, with one write
// port and one registered read port, moves one entry a cycle.
// The result sits in an output register, so a new item is taken while it waits.
// Reset (rst, synchronous) empties the store; no clearing pass is needed.
module indexed_insert_remove_array_core
  import iira_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // position[6:0], value[38:7], zero pad
  input  logic [1:0]            s_tuser,   // cmd[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // old_value[31:0], count[38:32], zero pad
  output logic [1:0]            m_tuser    // status[1:0]
);

  // Entry memory: one write port, one registered read port
  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rdata;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [VALUE_W-1:0] mem_wdata;

  fsm_t               state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [ADDR_W-1:0]  rd_addr, rd_addr_next;
  logic [VALUE_W-1:0] op_old, op_old_next;
  status_t            op_status, op_status_next;

  // Captured item
  cmd_t               op_cmd;
  logic [ADDR_W-1:0]  op_addr;
  logic [VALUE_W-1:0] op_value;

  // Output register
  logic [VALUE_W-1:0] out_old;
  logic [COUNT_W-1:0] out_count;
  status_t            out_status;
  logic               out_load;

  logic               s_xfer;
  cmd_t               in_cmd;
  logic [POS_W-1:0]   in_pos;
  logic [VALUE_W-1:0] in_value;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   cnt_ext;
  logic [ADDR_W-1:0]  pos_addr;
  logic               at_top;

  assign s_tready = !rst && (state == S_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign in_cmd   = cmd_t'(s_tuser);
  assign in_pos   = s_tdata[POS_W-1:0];
  assign in_value = s_tdata[POS_W+VALUE_W-1:POS_W];
  assign pos_ext  = CMP_W'(in_pos);
  assign cnt_ext  = CMP_W'(count);
  assign pos_addr = ADDR_W'(in_pos);
  // Last live entry reached, on a remove's load or during a downward shift
  assign at_top   = ((CNT_W'(rd_addr) + CNT_W'(1)) == count);

  assign m_tdata  = OUT_DATA_W'({out_count, out_old});
  assign m_tuser  = out_status;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_addr   <= rd_addr_next;
    op_old    <= op_old_next;
    op_status <= op_status_next;
    if (s_xfer) begin
      op_cmd   <= in_cmd;
      op_addr  <= pos_addr;
      op_value <= in_value;
    end
    if (out_load) begin
      out_old    <= op_old;
      out_status <= op_status;
      out_count  <= COUNT_W'(count);
    end
  end

  // Sequencer: next state, memory port and result control
  always_comb begin
    state_next     = state;
    count_next     = count;
    rd_addr_next   = rd_addr;
    op_old_next    = op_old;
    op_status_next = op_status;
    mem_we         = 1'b0;
    mem_waddr      = rd_addr;
    mem_wdata      = rdata;
    mem_raddr      = rd_addr;
    out_load       = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_xfer) begin
          op_old_next    = '0;
          op_status_next = STAT_OK;
          case (in_cmd)
            CMD_INSERT: begin
              if (cnt_ext == CMP_W'(CAPACITY)) begin
                op_status_next = STAT_FULL;
                state_next     = S_RESP;
              end else if (pos_ext > cnt_ext) begin
                op_status_next = STAT_RANGE;
                state_next     = S_RESP;
              end else if (pos_ext == cnt_ext) begin
                // Append: no entries to move
                mem_we     = 1'b1;
                mem_waddr  = pos_addr;
                mem_wdata  = in_value;
                count_next = count + CNT_W'(1);
                state_next = S_RESP;
              end else begin
                // Start moving from the top entry down to the index
                mem_raddr    = ADDR_W'(count - CNT_W'(1));
                rd_addr_next = ADDR_W'(count - CNT_W'(1));
                state_next   = S_SHIFT_UP;
              end
            end
            default: begin
              if (pos_ext >= cnt_ext) begin
                op_status_next = STAT_RANGE;
                state_next     = S_RESP;
              end else begin
                mem_raddr    = pos_addr;
                rd_addr_next = pos_addr;
                state_next   = S_LOAD;
              end
            end
          endcase
        end
      end
      S_LOAD: begin
        // rdata holds the entry at the index
        op_old_next = rdata;
        case (op_cmd)
          CMD_REMOVE: begin
            if (at_top) begin
              count_next = count - CNT_W'(1);
              state_next = S_RESP;
            end else begin
              mem_raddr    = rd_addr + ADDR_W'(1);
              rd_addr_next = rd_addr + ADDR_W'(1);
              state_next   = S_SHIFT_DN;
            end
          end
          CMD_REPLACE: begin
            mem_we     = 1'b1;
            mem_waddr  = op_addr;
            mem_wdata  = op_value;
            state_next = S_RESP;
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_SHIFT_UP: begin
        // Move one entry up a place, fetch the one below
        mem_we    = 1'b1;
        mem_waddr = rd_addr + ADDR_W'(1);
        if (rd_addr == op_addr) begin
          state_next = S_INS_LAST;
        end else begin
          mem_raddr    = rd_addr - ADDR_W'(1);
          rd_addr_next = rd_addr - ADDR_W'(1);
        end
      end
      S_INS_LAST: begin
        mem_we     = 1'b1;
        mem_waddr  = op_addr;
        mem_wdata  = op_value;
        count_next = count + CNT_W'(1);
        state_next = S_RESP;
      end
      S_SHIFT_DN: begin
        // Move one entry down a place, fetch the one above
        mem_we    = 1'b1;
        mem_waddr = rd_addr - ADDR_W'(1);
        if (at_top) begin
          count_next = count - CNT_W'(1);
          state_next = S_RESP;
        end else begin
          mem_raddr    = rd_addr + ADDR_W'(1);
          rd_addr_next = rd_addr + ADDR_W'(1);
        end
      end
      S_RESP: begin
        // Hand the result over once the output register is free
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Live count stays within the store
  assert property (@(posedge clk) disable iff (rst) CNT_W'(count) <= CNT_W'(CAPACITY))
    else $error("live count above capacity");

  // Count moves by at most one entry per cycle
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count)) || (count == $past(count) + CNT_W'(1)) ||
             (count == $past(count) - CNT_W'(1)))
    else $error("live count jumped");

  // A failed operation returns a zero word
  assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_tuser == STAT_OK) || (m_tdata[VALUE_W-1:0] == '0))
    else $error("nonzero word on error result");

  // Upward shift never walks below the insert index
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT_UP) |-> (rd_addr >= op_addr))
    else $error("shift passed insert index");

endmodule
